@@ sv/glyph_cell_bounding_box_top_assert.svh @@
// Assertion macros shared by the glyph cell bounding box RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef GLYPH_CELL_BOUNDING_BOX_TOP_ASSERT_SVH
`define GLYPH_CELL_BOUNDING_BOX_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCBB_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gcbb_pkg.sv @@
// Package for the glyph cell bounding box: types, register codes and reset values.
// Used by gcbb_acc and glyph_cell_bounding_box_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gcbb_pkg;

	localparam int COORD_W   = 8;
	localparam int GLYPH_W   = 7;
	localparam int OFFS_W    = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] LOW_THR_RST   = 8'd20;
	localparam logic [7:0] EDGE_THR_RST  = 8'd200;
	localparam logic [7:0] CELL_SIZE_RST = 8'd16;
	localparam logic [4:0] CELL_COLS_RST = 5'd16;
	localparam logic [7:0] TOP_RST       = 8'hFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_THR   = 3'd0,
		CFG_EDGE_THR  = 3'd1,
		CFG_CELL_W    = 3'd2,
		CFG_CELL_H    = 3'd3,
		CFG_CELL_COLS = 3'd4
	} cfg_reg_t;

	typedef logic [COORD_W-1:0] coord_t;

	// One cell accumulator entry.
	typedef struct packed {
		logic   any;
		coord_t lo_x;
		coord_t hi_x;
		coord_t lo_y;
		coord_t hi_y;
		coord_t edge_x;
		coord_t edge_y;
	} acc_t;

	// Pixel as it leaves the raster stage.
	typedef struct packed {
		logic               frame_start;
		logic               start;
		logic               final_px;
		logic               last_glyph;
		logic               low_hit;
		logic               edge_hit;
		coord_t             x;
		coord_t             y;
		logic [GLYPH_W-1:0] glyph;
	} pix_t;

	// Finished cell as it leaves the accumulator.
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic               last_glyph;
		acc_t               acc;
		coord_t             top;
		coord_t             bottom;
	} res_t;

endpackage

`default_nettype wire

@@ sv/glyph_cell_bounding_box_top.sv @@
// Top level of the glyph cell bounding box: config registers, raster counters,
// output register. Depends on gcbb_pkg, gcbb_acc and the assertion macro header.
//
//   Channel   Handshake                Payload
//   --------  -----------------------  ------------------------------------------
//   pixel in  in_valid / in_stall      alpha, frame_start
//   result    out_valid / out_stall    glyph_index .. last (one per finished cell)
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel is taken per cycle while in_stall is low. A result passes stage 1,
// stage 2 and the output register before it shows on out_valid. The accumulator
// memory is read as a pixel is taken and written back from stage 1; a stage 2
// bypass covers the same entry. in_stall rises only when a finished cell waits in
// stage 2 behind a held result. Reset clears counters and extents; accumulator
// entries start on a cell's first pixel, so the memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_cell_bounding_box_top_assert.svh"

module glyph_cell_bounding_box_top #(
	parameter int MAX_COLUMNS = 16,
	parameter int GLYPH_COUNT = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       alpha,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gcbb_pkg::GLYPH_W-1:0]     glyph_index,
	output logic                             empty_res,
	output logic [7:0]                       box_left,
	output logic [7:0]                       box_top,
	output logic [7:0]                       box_width,
	output logic [7:0]                       box_height,
	output logic signed [gcbb_pkg::OFFS_W-1:0] edge_offset_x,
	output logic signed [gcbb_pkg::OFFS_W-1:0] edge_offset_y,
	output logic [7:0]                       global_top,
	output logic [7:0]                       global_bottom,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gcbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data
);
	import gcbb_pkg::*;

	localparam int NW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(GLYPH_COUNT + 1);
	localparam int IW = $clog2(GLYPH_COUNT + MAX_COLUMNS + 1);

	// Configuration registers.
	logic [7:0]     low_thr_q;
	logic [7:0]     edge_thr_q;
	coord_t         cell_w_q;
	coord_t         cell_h_q;
	logic [4:0]     cell_cols_q;

	// Raster position.
	coord_t         x_q;
	coord_t         y_q;
	logic [NW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           done_q;

	// Output register.
	logic           out_valid_q;
	res_t           out_q;

	coord_t         w_eff;
	coord_t         h_eff;
	logic [NW-1:0]  cols_eff;
	coord_t         x0;
	coord_t         y0;
	logic [NW-1:0]  col_c;
	logic [NW-1:0]  col0;
	logic [RW-1:0]  row0;
	logic           done0;
	logic [IW-1:0]  idx;
	logic [IW-1:0]  row_sum;
	logic [COORD_W:0] x_inc;
	logic [COORD_W:0] y_inc;
	logic [NW:0]    col_inc;
	logic           active;
	logic           accept;
	logic           adv;
	logic           out_free;
	logic           acc_in_v;
	pix_t           pix;
	logic           res_valid;
	res_t           res;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q   <= LOW_THR_RST;
			edge_thr_q  <= EDGE_THR_RST;
			cell_w_q    <= CELL_SIZE_RST;
			cell_h_q    <= CELL_SIZE_RST;
			cell_cols_q <= CELL_COLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOW_THR:   low_thr_q   <= cfg_data;
				CFG_EDGE_THR:  edge_thr_q  <= cfg_data;
				CFG_CELL_W:    cell_w_q    <= cfg_data;
				CFG_CELL_H:    cell_h_q    <= cfg_data;
				CFG_CELL_COLS: cell_cols_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Effective sizes: zero acts as one, columns saturate at the memory depth.
	always_comb begin
		w_eff = (cell_w_q == '0) ? COORD_W'(1) : cell_w_q;
		h_eff = (cell_h_q == '0) ? COORD_W'(1) : cell_h_q;
		if (cell_cols_q == '0) begin
			cols_eff = NW'(1);
		end else if (int'(cell_cols_q) > MAX_COLUMNS) begin
			cols_eff = NW'(MAX_COLUMNS);
		end else begin
			cols_eff = NW'(cell_cols_q);
		end
	end

	// Handshake: stall only when a finished cell cannot move to the output.
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = !res_valid || out_free;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// Current pixel position, with a frame start applied first.
	always_comb begin
		x0    = frame_start ? '0 : x_q;
		y0    = frame_start ? '0 : y_q;
		col_c = frame_start ? '0 : col_q;
		row0  = frame_start ? '0 : row_q;
		done0 = frame_start ? 1'b0 : done_q;
		col0  = (col_c >= cols_eff) ? '0 : col_c;
		idx   = IW'(row0) + IW'(col0);
		x_inc = {1'b0, x0} + 1'b1;
		y_inc = {1'b0, y0} + 1'b1;
		col_inc = {1'b0, col0} + 1'b1;
		row_sum = IW'(row0) + IW'(cols_eff);
		active  = !done0 && (idx < IW'(GLYPH_COUNT));

		pix.frame_start = frame_start;
		pix.start       = (x0 == '0) && (y0 == '0);
		pix.final_px    = (x_inc >= {1'b0, w_eff}) && (y_inc >= {1'b0, h_eff});
		pix.last_glyph  = pix.final_px && active && (idx == IW'(GLYPH_COUNT - 1));
		pix.low_hit     = alpha > low_thr_q;
		pix.edge_hit    = alpha >= edge_thr_q;
		pix.x           = x0;
		pix.y           = y0;
		pix.glyph       = GLYPH_W'(idx);
	end

	assign acc_in_v = accept && active;

	// Raster counters advance on every transfer until the atlas is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (accept && !done0) begin
			done_q <= pix.last_glyph;
			if (x_inc < {1'b0, w_eff}) begin
				x_q   <= x_inc[COORD_W-1:0];
				y_q   <= y0;
				col_q <= col0;
				row_q <= row0;
			end else begin
				x_q <= '0;
				if (col_inc < {1'b0, cols_eff}) begin
					col_q <= col_inc[NW-1:0];
					y_q   <= y0;
					row_q <= row0;
				end else begin
					col_q <= '0;
					if (y_inc < {1'b0, h_eff}) begin
						y_q   <= y_inc[COORD_W-1:0];
						row_q <= row0;
					end else begin
						y_q   <= '0;
						row_q <= (row_sum > IW'(GLYPH_COUNT)) ? RW'(GLYPH_COUNT)
						                                      : RW'(row_sum);
					end
				end
			end
		end
	end

	gcbb_acc #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (acc_in_v),
		.pix      (pix),
		.col      (col0),
		.cell_w   (w_eff),
		.cell_h   (h_eff),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	// Result fields; an empty cell reports a zero box and zero offsets.
	assign out_valid     = out_valid_q;
	assign glyph_index   = out_q.glyph;
	assign empty_res     = !out_q.acc.any;
	assign box_left      = out_q.acc.any ? out_q.acc.lo_x : '0;
	assign box_top       = out_q.acc.any ? out_q.acc.lo_y : '0;
	assign box_width     = out_q.acc.any ? (out_q.acc.hi_x - out_q.acc.lo_x + 8'd1) : '0;
	assign box_height    = out_q.acc.any ? (out_q.acc.hi_y - out_q.acc.lo_y + 8'd1) : '0;
	assign edge_offset_x = out_q.acc.any
		? $signed({1'b0, out_q.acc.edge_x} - {1'b0, out_q.acc.lo_x}) : '0;
	assign edge_offset_y = out_q.acc.any
		? $signed({1'b0, out_q.acc.edge_y} - {1'b0, out_q.acc.lo_y}) : '0;
	assign global_top    = out_q.top;
	assign global_bottom = out_q.bottom;
	assign last          = out_q.last_glyph;

	`GCBB_ASSERT(a_last_is_final_glyph, out_valid_q && out_q.last_glyph, out_q.glyph == GLYPH_W'(GLYPH_COUNT - 1), "last flag on wrong glyph")
	`GCBB_ASSERT(a_done_blocks_cells, accept && done_q && !frame_start, !acc_in_v, "pixel accumulated after atlas end")
	`GCBB_ASSERT_NEXT(a_final_sets_done, acc_in_v && pix.last_glyph, done_q, "atlas end not recorded")

endmodule

`default_nettype wire

@@ sv/gcbb_acc.sv @@
// Cell accumulator memory with read-modify-write pipeline and running extents.
// Depends on gcbb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_cell_bounding_box_top_assert.svh"

module gcbb_acc #(
	parameter int MAX_COLUMNS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_v,
	input  gcbb_pkg::pix_t                     pix,
	input  logic [$clog2(MAX_COLUMNS+1)-1:0]   col,
	input  gcbb_pkg::coord_t                   cell_w,
	input  gcbb_pkg::coord_t                   cell_h,
	output logic                               res_valid,
	output gcbb_pkg::res_t                     res
);
	import gcbb_pkg::*;

	localparam int NW = $clog2(MAX_COLUMNS + 1);
	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	acc_t             mem [MAX_COLUMNS];
	acc_t             rd_q;

	logic             v_s1;
	pix_t             pix_s1;
	logic [NW-1:0]    col_s1;

	logic             v_s2;
	acc_t             acc_s2;
	logic [NW-1:0]    col_s2;
	logic             final_s2;
	logic             last_s2;
	logic [GLYPH_W-1:0] glyph_s2;
	coord_t           top_s2;
	coord_t           bot_s2;

	coord_t           run_top_q;
	coord_t           run_bot_q;

	logic             fwd;
	acc_t             base;
	acc_t             acc_new;
	coord_t           top_base;
	coord_t           bot_base;
	coord_t           top_new;
	coord_t           bot_new;

	// Pick the entry the pixel updates: fresh at a cell's first pixel, else the
	// stage 2 copy when it was written while this read was in flight.
	always_comb begin
		fwd = v_s2 && (col_s2 == col_s1);
		priority if (pix_s1.start) begin
			base.any    = 1'b0;
			base.lo_x   = '0;
			base.hi_x   = '0;
			base.lo_y   = '0;
			base.hi_y   = '0;
			base.edge_x = cell_w;
			base.edge_y = cell_h;
		end else if (fwd) begin
			base = acc_s2;
		end else begin
			base = rd_q;
		end
	end

	// Merge the pixel into the box and the edge minimums.
	always_comb begin
		acc_new = base;
		if (pix_s1.low_hit) begin
			if (!base.any) begin
				acc_new.any  = 1'b1;
				acc_new.lo_x = pix_s1.x;
				acc_new.hi_x = pix_s1.x;
				acc_new.lo_y = pix_s1.y;
				acc_new.hi_y = pix_s1.y;
			end else begin
				if (pix_s1.x < base.lo_x) acc_new.lo_x = pix_s1.x;
				if (pix_s1.x > base.hi_x) acc_new.hi_x = pix_s1.x;
				if (pix_s1.y < base.lo_y) acc_new.lo_y = pix_s1.y;
				if (pix_s1.y > base.hi_y) acc_new.hi_y = pix_s1.y;
			end
		end
		if (pix_s1.edge_hit) begin
			if (pix_s1.x < base.edge_x) acc_new.edge_x = pix_s1.x;
			if (pix_s1.y < base.edge_y) acc_new.edge_y = pix_s1.y;
		end
	end

	// Running vertical extents; a frame start reloads them before this cell.
	always_comb begin
		top_base = pix_s1.frame_start ? cell_h : run_top_q;
		bot_base = pix_s1.frame_start ? '0 : run_bot_q;
		top_new  = top_base;
		bot_new  = bot_base;
		if (pix_s1.final_px && acc_new.any) begin
			if (acc_new.lo_y < top_base) top_new = acc_new.lo_y;
			if (acc_new.hi_y > bot_base) bot_new = acc_new.hi_y;
		end
	end

	// Accumulator memory: write back from stage 1, read for the incoming pixel.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s1) begin
				mem[col_s1[AW-1:0]] <= acc_new;
			end
			rd_q <= mem[col[AW-1:0]];
		end
	end

	// Stage valids and running extents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			run_top_q <= TOP_RST;
			run_bot_q <= '0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			if (v_s1) begin
				run_top_q <= top_new;
				run_bot_q <= bot_new;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1   <= pix;
			col_s1   <= col;
			acc_s2   <= acc_new;
			col_s2   <= col_s1;
			final_s2 <= pix_s1.final_px;
			last_s2  <= pix_s1.last_glyph;
			glyph_s2 <= pix_s1.glyph;
			top_s2   <= top_new;
			bot_s2   <= bot_new;
		end
	end

	assign res_valid      = v_s2 && final_s2;
	assign res.glyph      = glyph_s2;
	assign res.last_glyph = last_s2;
	assign res.acc        = acc_s2;
	assign res.top        = top_s2;
	assign res.bottom     = bot_s2;

	`GCBB_ASSERT(a_hold_only_on_result, !adv, res_valid, "pipeline held with no finished cell")
	`GCBB_ASSERT(a_top_covers_box, res_valid && acc_s2.any, top_s2 <= acc_s2.lo_y, "global top above box")
	`GCBB_ASSERT(a_bot_covers_box, res_valid && acc_s2.any, bot_s2 >= acc_s2.hi_y, "global bottom below box")

endmodule

`default_nettype wire

@@ tb/sv/tb_glyph_cell_bounding_box_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for glyph_cell_bounding_box_top: directed pixels, then random atlases.
// Depends on gcbb_pkg and the RTL; predicts each cell result and compares it field by field.

module tb_glyph_cell_bounding_box_top;
	import gcbb_pkg::*;

	localparam int GLYPHS     = 128;
	localparam int MAX_COLS   = 16;
	localparam int SETTLE     = 6;
	localparam int LONG_HOLD  = 150;
	localparam int IDLE_LIMIT = 3000;
	localparam int PRINT_CAP  = 40;

	// One finished cell as seen on the result port.
	typedef struct packed {
		logic [6:0]        glyph;
		logic              empty;
		logic [7:0]        left;
		logic [7:0]        top;
		logic [7:0]        width;
		logic [7:0]        height;
		logic signed [8:0] offx;
		logic signed [8:0] offy;
		logic [7:0]        gtop;
		logic [7:0]        gbot;
		logic              last;
	} bbox_res_t;

	// Per-column accumulator of the predictor.
	typedef struct {
		bit any;
		int lo_x;
		int hi_x;
		int lo_y;
		int hi_y;
		int edge_x;
		int edge_y;
	} cell_span_t;

	// One register setting and the number of used pixels to run under it.
	typedef struct {
		int lo;
		int ed;
		int w;
		int h;
		int cols;
		int budget;
	} setting_t;

	// One directed pixel; typed rows carry the result read off by hand.
	typedef struct packed {
		logic [7:0] a;
		logic       fs;
		logic       typed;
		bbox_res_t  want;
	} probe_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        alpha = 8'd0;
	logic              frame_start = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [6:0]        glyph_index;
	logic              empty_res;
	logic [7:0]        box_left;
	logic [7:0]        box_top;
	logic [7:0]        box_width;
	logic [7:0]        box_height;
	logic signed [8:0] edge_offset_x;
	logic signed [8:0] edge_offset_y;
	logic [7:0]        global_top;
	logic [7:0]        global_bottom;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index = CFG_LOW_THR;
	logic [7:0]        cfg_data = 8'd0;

	// Hand-typed expectation that travels with a directed pixel.
	logic              probe_typed = 1'b0;
	bbox_res_t         probe_want = '0;

	// Predictor copy of the registers and the raster state.
	int                thr_low = LOW_THR_RST;
	int                thr_edge = EDGE_THR_RST;
	int                cell_w = CELL_SIZE_RST;
	int                cell_h = CELL_SIZE_RST;
	int                cell_cols = CELL_COLS_RST;
	cell_span_t        spans [MAX_COLS];
	int                pos_x = 0;
	int                pos_y = 0;
	int                col_now = 0;
	int                row_base = 0;
	int                run_top = TOP_RST;
	int                run_bot = 0;
	bit                atlas_closed = 1'b0;

	bbox_res_t         pending_boxes [$];
	int                outstanding = 0;
	int                pixels_used = 0;
	int                results_seen = 0;
	int                offered_n = 0;
	int                errors = 0;
	bit                sender_steady = 1'b0;

	// Directed pixels on 1x1 cells, four columns.
	probe_row_t probes [13] = '{
		'{8'd0,   1'b0, 1'b1, '{7'd0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 9'sd0, 9'sd0,
			8'd255, 8'd0, 1'b0}},
		'{8'd20,  1'b0, 1'b1, '{7'd1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 9'sd0, 9'sd0,
			8'd255, 8'd0, 1'b0}},
		'{8'd21,  1'b0, 1'b1, '{7'd2, 1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 9'sd1, 9'sd1,
			8'd0, 8'd0, 1'b0}},
		'{8'd199, 1'b0, 1'b1, '{7'd3, 1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 9'sd1, 9'sd1,
			8'd0, 8'd0, 1'b0}},
		'{8'd200, 1'b0, 1'b1, '{7'd4, 1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 9'sd0, 9'sd0,
			8'd0, 8'd0, 1'b0}},
		'{8'd255, 1'b1, 1'b1, '{7'd0, 1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 9'sd0, 9'sd0,
			8'd0, 8'd0, 1'b0}},
		'{8'd0,   1'b1, 1'b1, '{7'd0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 9'sd0, 9'sd0,
			8'd1, 8'd0, 1'b0}},
		'{8'd170, 1'b0, 1'b0, '0},
		'{8'd85,  1'b0, 1'b0, '0},
		'{8'd1,   1'b1, 1'b0, '0},
		'{8'd254, 1'b0, 1'b0, '0},
		'{8'd128, 1'b0, 1'b0, '0},
		'{8'd127, 1'b0, 1'b0, '0}
	};

	glyph_cell_bounding_box_top dut (
		.clk, .arst_n, .in_valid, .in_stall, .alpha, .frame_start,
		.out_valid, .out_stall, .glyph_index, .empty_res, .box_left, .box_top,
		.box_width, .box_height, .edge_offset_x, .edge_offset_y, .global_top,
		.global_bottom, .last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #4 clk = ~clk;

	// Counts one mismatch and prints it, up to a cap.
	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
	endtask

	// Advances the predictor by one pixel; returns 1 when the pixel closes a cell.
	function automatic bit step_cell_boxes(input logic [7:0] a, input logic fs,
			output bbox_res_t r, output bit used);
		int w;
		int h;
		int nc;
		int x;
		int y;
		int c;
		int idx;
		int dx;
		int dy;
		bit hit;
		r = '0;
		used = 1'b0;
		hit = 1'b0;
		w = (cell_w == 0) ? 1 : cell_w;
		h = (cell_h == 0) ? 1 : cell_h;
		nc = (cell_cols == 0) ? 1 : ((cell_cols > MAX_COLS) ? MAX_COLS : cell_cols);
		if (fs) begin
			pos_x = 0;
			pos_y = 0;
			col_now = 0;
			row_base = 0;
			atlas_closed = 1'b0;
			run_top = h % 256;
			run_bot = 0;
		end
		if (atlas_closed)
			return 1'b0;
		if (col_now >= nc)
			col_now = 0;
		x = pos_x;
		y = pos_y;
		c = col_now;
		idx = row_base + c;
		if (idx < GLYPHS) begin
			used = 1'b1;
			// The first pixel of a cell restarts its column accumulator.
			if (x == 0 && y == 0) begin
				spans[c].any = 1'b0;
				spans[c].lo_x = 0;
				spans[c].hi_x = 0;
				spans[c].lo_y = 0;
				spans[c].hi_y = 0;
				spans[c].edge_x = w;
				spans[c].edge_y = h;
			end
			if (a > thr_low) begin
				if (!spans[c].any) begin
					spans[c].any = 1'b1;
					spans[c].lo_x = x;
					spans[c].hi_x = x;
					spans[c].lo_y = y;
					spans[c].hi_y = y;
				end else begin
					if (x < spans[c].lo_x) spans[c].lo_x = x;
					if (x > spans[c].hi_x) spans[c].hi_x = x;
					if (y < spans[c].lo_y) spans[c].lo_y = y;
					if (y > spans[c].hi_y) spans[c].hi_y = y;
				end
			end
			if (a >= thr_edge) begin
				if (x < spans[c].edge_x) spans[c].edge_x = x;
				if (y < spans[c].edge_y) spans[c].edge_y = y;
			end
			// The last pixel of a cell produces its result.
			if (x + 1 >= w && y + 1 >= h) begin
				hit = 1'b1;
				r.glyph = idx[6:0];
				if (!spans[c].any) begin
					r.empty = 1'b1;
				end else begin
					if (spans[c].lo_y < run_top) run_top = spans[c].lo_y;
					if (spans[c].hi_y > run_bot) run_bot = spans[c].hi_y;
					dx = spans[c].edge_x - spans[c].lo_x;
					dy = spans[c].edge_y - spans[c].lo_y;
					r.left = spans[c].lo_x[7:0];
					r.top = spans[c].lo_y[7:0];
					r.width = 8'(spans[c].hi_x - spans[c].lo_x + 1);
					r.height = 8'(spans[c].hi_y - spans[c].lo_y + 1);
					r.offx = dx[8:0];
					r.offy = dy[8:0];
				end
				r.gtop = run_top[7:0];
				r.gbot = run_bot[7:0];
				r.last = (idx == GLYPHS - 1);
				if (idx == GLYPHS - 1)
					atlas_closed = 1'b1;
			end
		end
		// Move the raster position on by one pixel.
		if (x + 1 < w) begin
			pos_x = (x + 1) % 256;
		end else begin
			pos_x = 0;
			if (c + 1 < nc) begin
				col_now = c + 1;
			end else begin
				col_now = 0;
				if (y + 1 < h) begin
					pos_y = (y + 1) % 256;
				end else begin
					pos_y = 0;
					row_base = row_base + nc;
					if (row_base > GLYPHS)
						row_base = GLYPHS;
				end
			end
		end
		return hit;
	endfunction

	// Alpha values weighted toward zero, the thresholds and full coverage.
	function automatic logic [7:0] pick_alpha(input int lo, input int ed);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'd0;
			4: return 8'(lo);
			5: return 8'(lo + 1);
			6: return 8'(ed);
			7: return 8'(ed - 1);
			8: return 8'($urandom_range(0, 255));
			default: return 8'd255;
		endcase
	endfunction

	// Offers one pixel after a random gap and returns at the edge of its transfer.
	task automatic send_pixel(input logic [7:0] a, input logic fs, input logic typed,
			input bbox_res_t want);
		int gap;
		if (offered_n % 40 == 0)
			sender_steady = ($urandom_range(0, 2) == 0);
		gap = (sender_steady || (offered_n >= 100 && offered_n < 260)) ? 0 :
			$urandom_range(0, 19);
		offered_n++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		alpha <= a;
		frame_start <= fs;
		probe_typed <= typed;
		probe_want <= want;
		do @(posedge clk); while (in_stall);
	endtask

	// Holds the register channel valid until this register is written.
	task automatic put_reg(input cfg_reg_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input int lo, input int ed, input int w, input int h,
			input int cols);
		put_reg(CFG_LOW_THR, 8'(lo));
		put_reg(CFG_EDGE_THR, 8'(ed));
		put_reg(CFG_CELL_W, 8'(w));
		put_reg(CFG_CELL_H, 8'(h));
		put_reg(CFG_CELL_COLS, 8'(cols));
		cfg_valid <= 1'b0;
	endtask

	// Stops offering pixels until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Stimulus: directed pixels, then random atlases under several settings.
	initial begin : stimulus
		setting_t plan [5];
		int base;
		int len;
		int k;
		int tail;
		plan[0] = '{20, 200, 1, 1, 16, 300};
		plan[1] = '{0, 255, 2, 2, 5, 540};
		plan[2] = '{255, 0, 255, 1, 1, 260};
		plan[3] = '{128, 64, 1, 255, 1, 260};
		plan[4] = '{$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 3),
			$urandom_range(1, 3), $urandom_range(1, 16), 200};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_settings(20, 200, 1, 1, 4);
		foreach (probes[i])
			send_pixel(probes[i].a, probes[i].fs, probes[i].typed, probes[i].want);
		for (int p = 0; p < 5; p++) begin
			drain();
			load_settings(plan[p].lo, plan[p].ed, plan[p].w, plan[p].h, plan[p].cols);
			base = pixels_used;
			while (pixels_used - base < plan[p].budget) begin
				// Mostly whole atlases; some are cut short by an early frame start.
				len = ((GLYPHS + plan[p].cols - 1) / plan[p].cols) * plan[p].cols *
					plan[p].w * plan[p].h;
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, len);
				for (k = 0; k < len && pixels_used - base < plan[p].budget; k++)
					send_pixel(pick_alpha(plan[p].lo, plan[p].ed),
						k == 0 || $urandom_range(0, 299) == 0, 1'b0, '0);
				tail = $urandom_range(0, 3);
				repeat (tail)
					send_pixel(pick_alpha(plan[p].lo, plan[p].ed), 1'b0, 1'b0, '0);
			end
		end
		drain();
		@(negedge clk);
		if (pending_boxes.size() != 0)
			report_mismatch("results never produced", 0, pending_boxes.size());
		$display("summary: %0d pixels offered, %0d inside the glyph range, %0d results checked",
			offered_n, pixels_used, results_seen);
		$display("summary: six settings incl. threshold, cell size and column extremes");
		if (errors == 0)
			$display("tb_glyph_cell_bounding_box_top: clean");
		else
			$display("tb_glyph_cell_bounding_box_top: errors");
		$finish;
	end

	// Result side: random stall per result, one long hold-off to back up the block.
	initial begin : result_side
		int taken_n;
		int hold;
		bit steady;
		taken_n = 0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken_n % 40 == 0)
				steady = ($urandom_range(0, 2) == 0);
			hold = steady ? 0 : $urandom_range(0, 19);
			if (taken_n == 150)
				hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken_n++;
		end
	end

	// Checks results, tracks register writes and predicts every pixel transfer.
	always @(posedge clk) begin : scoreboard
		bbox_res_t got;
		bbox_res_t want;
		bbox_res_t fresh;
		bit used;
		bit busy;
		int idle_cycles;
		busy = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				got = '{glyph_index, empty_res, box_left, box_top, box_width, box_height,
					edge_offset_x, edge_offset_y, global_top, global_bottom, last};
				if (pending_boxes.size() == 0) begin
					report_mismatch("result with nothing expected, glyph_index", got.glyph, -1);
				end else begin
					want = pending_boxes.pop_front();
					if (got.glyph !== want.glyph)
						report_mismatch("glyph_index", got.glyph, want.glyph);
					if (got.empty !== want.empty)
						report_mismatch("empty_res", got.empty, want.empty);
					if (got.left !== want.left)
						report_mismatch("box_left", got.left, want.left);
					if (got.top !== want.top)
						report_mismatch("box_top", got.top, want.top);
					if (got.width !== want.width)
						report_mismatch("box_width", got.width, want.width);
					if (got.height !== want.height)
						report_mismatch("box_height", got.height, want.height);
					if (got.offx !== want.offx)
						report_mismatch("edge_offset_x", got.offx, want.offx);
					if (got.offy !== want.offy)
						report_mismatch("edge_offset_y", got.offy, want.offy);
					if (got.gtop !== want.gtop)
						report_mismatch("global_top", got.gtop, want.gtop);
					if (got.gbot !== want.gbot)
						report_mismatch("global_bottom", got.gbot, want.gbot);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
				results_seen <= results_seen + 1;
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				case (cfg_index)
					CFG_LOW_THR:   thr_low = cfg_data;
					CFG_EDGE_THR:  thr_edge = cfg_data;
					CFG_CELL_W:    cell_w = cfg_data;
					CFG_CELL_H:    cell_h = cfg_data;
					CFG_CELL_COLS: cell_cols = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				busy = 1'b1;
				if (step_cell_boxes(alpha, frame_start, fresh, used))
					pending_boxes.push_back(probe_typed ? probe_want : fresh);
				if (used)
					pixels_used <= pixels_used + 1;
			end
			outstanding <= pending_boxes.size();
			// A long stretch without any transfer means the block has hung.
			if (busy)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("tb_glyph_cell_bounding_box_top: errors");
				$finish;
			end
		end
	end

endmodule
